[sv/tlpt_pkg.sv]
// tlpt_pkg: shared constants, beat types, memory port structs and helper
// functions for the two-level page table unit. No dependencies.
package tlpt_pkg;

  localparam int MaxPageBits = 16;
  localparam int PoolPages   = 16;
  localparam int FrameW      = 16;

  localparam int BitsW      = 5;
  localparam int DirIdxW    = MaxPageBits / 2;
  localparam int EntIdxW    = MaxPageBits - MaxPageBits / 2;
  localparam int DirSlots   = 1 << DirIdxW;
  localparam int PoolIdxW   = (PoolPages > 1) ? $clog2(PoolPages) : 1;
  localparam int CountW     = $clog2(PoolPages + 1);
  localparam int EntAddrW   = PoolIdxW + EntIdxW;
  localparam int EntDepth   = 1 << EntAddrW;
  localparam int MemBytesW  = 15;
  localparam logic [BitsW-1:0] BitsReset = BitsW'(16);

  typedef enum logic [1:0] {
    ACT_LOOKUP = 2'd0,
    ACT_INSERT = 2'd1,
    ACT_INVAL  = 2'd2,
    ACT_CLEAR  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_NOT_MAPPED = 2'd1,
    ST_RANGE      = 2'd2,
    ST_POOL_FULL  = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_DIR,
    S_ENT,
    S_CLR
  } state_e;

  typedef struct packed {
    action_e     action;
    logic [15:0] page_num;
    logic [15:0] frame_number;
  } in_beat_t;

  typedef struct packed {
    logic [15:0]          frame_out;
    logic                 hit;
    status_e              status;
    logic [4:0]           pages_in_use;
    logic [MemBytesW-1:0] memory_bytes;
  } out_beat_t;

  typedef struct packed {
    logic               in_range;
    logic [DirIdxW-1:0] i1;
    logic [EntIdxW-1:0] i2;
  } dec_t;

  typedef struct packed {
    logic [PoolIdxW-1:0] pool;
  } dir_rd_t;

  typedef struct packed {
    logic                en;
    logic [DirIdxW-1:0]  idx;
    logic [PoolIdxW-1:0] pool;
  } dir_wr_t;

  typedef struct packed {
    logic              valid;
    logic [FrameW-1:0] frame;
  } ent_t;

  typedef struct packed {
    logic                en;
    logic [EntAddrW-1:0] addr;
    ent_t                data;
  } ent_wr_t;

  // Clamp the page-number width into the supported range.
  function automatic logic [BitsW-1:0] clamp_bits(logic [BitsW-1:0] b);
    logic [BitsW-1:0] r;
    r = b;
    if (b < BitsW'(2)) r = BitsW'(2);
    else if (b > BitsW'(MaxPageBits)) r = BitsW'(MaxPageBits);
    return r;
  endfunction

  // Split a virtual page into directory and second-level index.
  function automatic dec_t decode(logic [15:0] vpage, logic [BitsW-1:0] bits);
    logic [BitsW-1:0] lo;
    logic [31:0]      vp;
    dec_t             d;
    lo = bits - (bits >> 1);
    vp = 32'(vpage);
    d.in_range = (vp >> bits) == 32'd0;
    d.i1 = DirIdxW'(vp >> lo);
    d.i2 = EntIdxW'(vp & ((32'd1 << lo) - 32'd1));
    return d;
  endfunction

  // slots*8 + count*entries*4, as shifts.
  function automatic logic [MemBytesW-1:0] mem_bytes(logic [CountW-1:0] count,
                                                     logic [BitsW-1:0] bits);
    logic [BitsW-1:0] hi;
    logic [BitsW-1:0] lo;
    logic [31:0]      s;
    hi = bits >> 1;
    lo = bits - hi;
    s  = (32'd8 << hi) + (32'(count) << (lo + BitsW'(2)));
    return MemBytesW'(s);
  endfunction

endpackage

[sv/tlpt_dir.sv]
// tlpt_dir: directory of the page table; present bits in flops and the
// pool index of each slot in a synchronous RAM. Uses tlpt_pkg.
module tlpt_dir (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          rd_en_i,
  input  logic [tlpt_pkg::DirIdxW-1:0]  rd_idx_i,
  output tlpt_pkg::dir_rd_t             rd_data_o,
  input  logic [tlpt_pkg::DirIdxW-1:0]  look_idx_i,
  output logic                          present_o,
  input  tlpt_pkg::dir_wr_t             wr_i,
  input  logic                          clr_i
);

  logic [tlpt_pkg::DirSlots-1:0] present_q;
  logic [tlpt_pkg::PoolIdxW-1:0] pool_mem [tlpt_pkg::DirSlots];
  tlpt_pkg::dir_rd_t             rd_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q <= '0;
    end else if (clr_i) begin
      present_q <= '0;
    end else if (wr_i.en) begin
      present_q[wr_i.idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      pool_mem[wr_i.idx] <= wr_i.pool;
    end
    if (rd_en_i) begin
      rd_q.pool <= pool_mem[rd_idx_i];
    end
  end

  assign rd_data_o = rd_q;
  assign present_o = present_q[look_idx_i];

endmodule

[sv/tlpt_entry_ram.sv]
// tlpt_entry_ram: second-level entries of all pool pages, one synchronous
// RAM with registered read data. Uses tlpt_pkg.
module tlpt_entry_ram (
  input  logic                           clk_i,
  input  logic                           rd_en_i,
  input  logic [tlpt_pkg::EntAddrW-1:0]  rd_addr_i,
  output tlpt_pkg::ent_t                 rd_data_o,
  input  tlpt_pkg::ent_wr_t              wr_i
);

  tlpt_pkg::ent_t mem [tlpt_pkg::EntDepth];
  tlpt_pkg::ent_t rd_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.en) begin
      mem[wr_i.addr] <= wr_i.data;
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_q;

endmodule

[sv/two_level_page_table_unit.sv]
// two_level_page_table_unit: lookup/insert/invalidate/clear on a two-level page table.
// Result register loads in S_DIR for clear, out-of-range and absent slot, in S_ENT when
// the entry RAM is read, and at the end of S_CLR for an insert that allocates a page
// (the new page's 256 entries are swept one per cycle through the entry RAM write port).
// Throughput: one item at a time, next beat taken the cycle after the result is loaded.
// Reset: async active low; directory empty, pool count 0, width 16. No clearing pass.
module two_level_page_table_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tlpt_pkg::BitsW-1:0]    cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  tlpt_pkg::in_beat_t            in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output tlpt_pkg::out_beat_t           out_data_o
);

  // Control state
  tlpt_pkg::state_e               state_q, state_d;
  logic [tlpt_pkg::BitsW-1:0]     bits_q;
  logic [tlpt_pkg::CountW-1:0]    count_q, count_d;
  logic [tlpt_pkg::EntIdxW-1:0]   cursor_q, cursor_d;
  logic                           out_valid_q;

  // Payload of the item in flight
  tlpt_pkg::action_e              act_q;
  tlpt_pkg::dec_t                 dec_q;
  logic [tlpt_pkg::FrameW-1:0]    frame_q;
  logic [tlpt_pkg::PoolIdxW-1:0]  page_q, page_d;
  tlpt_pkg::out_beat_t            out_q;

  // Memory ports
  tlpt_pkg::dir_rd_t              dir_rd;
  tlpt_pkg::dir_wr_t              dir_wr;
  logic                           dir_clr;
  logic                           present;
  logic                           ent_rd_en;
  logic [tlpt_pkg::EntAddrW-1:0]  ent_rd_addr;
  tlpt_pkg::ent_t                 ent_rd;
  tlpt_pkg::ent_wr_t              ent_wr;

  tlpt_pkg::dec_t                 in_dec;
  logic                           in_acc;
  logic                           out_free;
  logic                           done;
  logic                           res_clear;
  tlpt_pkg::out_beat_t            res;

  assign in_stall_o = (state_q != tlpt_pkg::S_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign in_dec     = tlpt_pkg::decode(in_data_i.page_num, bits_q);
  // Result register can load this cycle
  assign out_free   = !out_valid_q || !out_stall_i;

  tlpt_dir u_dir (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_acc),
    .rd_idx_i   (in_dec.i1),
    .rd_data_o  (dir_rd),
    .look_idx_i (dec_q.i1),
    .present_o  (present),
    .wr_i       (dir_wr),
    .clr_i      (dir_clr)
  );

  tlpt_entry_ram u_ent (
    .clk_i     (clk_i),
    .rd_en_i   (ent_rd_en),
    .rd_addr_i (ent_rd_addr),
    .rd_data_o (ent_rd),
    .wr_i      (ent_wr)
  );

  // Next state, memory commands and result assembly
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    cursor_d    = cursor_q;
    page_d      = page_q;
    dir_wr      = '0;
    dir_clr     = cfg_we_i;
    ent_rd_en   = 1'b0;
    ent_rd_addr = {dir_rd.pool, dec_q.i2};
    ent_wr      = '0;
    done        = 1'b0;
    res_clear   = 1'b0;
    res         = '0;
    res.status  = tlpt_pkg::ST_OK;

    case (state_q)
      tlpt_pkg::S_IDLE: begin
        if (in_acc) state_d = tlpt_pkg::S_DIR;
      end

      tlpt_pkg::S_DIR: begin
        if (act_q == tlpt_pkg::ACT_CLEAR) begin
          done      = 1'b1;
          res_clear = 1'b1;
          if (out_free) begin
            dir_clr = 1'b1;
            count_d = '0;
          end
        end else if (!dec_q.in_range) begin
          done       = 1'b1;
          res.status = tlpt_pkg::ST_RANGE;
        end else if (!present) begin
          if (act_q != tlpt_pkg::ACT_INSERT) begin
            done       = 1'b1;
            res.status = tlpt_pkg::ST_NOT_MAPPED;
          end else if (count_q >= tlpt_pkg::CountW'(tlpt_pkg::PoolPages)) begin
            done       = 1'b1;
            res.status = tlpt_pkg::ST_POOL_FULL;
          end else begin
            // Allocate the next pool page, then sweep it clean
            dir_wr.en   = 1'b1;
            dir_wr.idx  = dec_q.i1;
            dir_wr.pool = count_q[tlpt_pkg::PoolIdxW-1:0];
            page_d      = count_q[tlpt_pkg::PoolIdxW-1:0];
            count_d     = count_q + 1'b1;
            cursor_d    = '0;
            state_d     = tlpt_pkg::S_CLR;
          end
        end else begin
          ent_rd_en = 1'b1;
          page_d    = dir_rd.pool;
          state_d   = tlpt_pkg::S_ENT;
        end
      end

      tlpt_pkg::S_CLR: begin
        // The inserted entry is written during the sweep itself
        ent_wr.en         = 1'b1;
        ent_wr.addr       = {page_q, cursor_q};
        ent_wr.data.valid = (cursor_q == dec_q.i2);
        ent_wr.data.frame = frame_q;
        if (cursor_q == '1) begin
          done = 1'b1;
          if (out_free) cursor_d = '0;
        end else begin
          cursor_d = cursor_q + 1'b1;
        end
      end

      tlpt_pkg::S_ENT: begin
        done = 1'b1;
        case (act_q)
          tlpt_pkg::ACT_LOOKUP: begin
            if (ent_rd.valid) begin
              res.hit       = 1'b1;
              res.frame_out = 16'(ent_rd.frame);
            end else begin
              res.status = tlpt_pkg::ST_NOT_MAPPED;
            end
          end
          tlpt_pkg::ACT_INSERT: begin
            ent_wr.en         = out_free;
            ent_wr.addr       = {page_q, dec_q.i2};
            ent_wr.data.valid = 1'b1;
            ent_wr.data.frame = frame_q;
          end
          default: begin
            if (ent_rd.valid) begin
              ent_wr.en         = out_free;
              ent_wr.addr       = {page_q, dec_q.i2};
              ent_wr.data.valid = 1'b0;
              ent_wr.data.frame = ent_rd.frame;
            end else begin
              res.status = tlpt_pkg::ST_NOT_MAPPED;
            end
          end
        endcase
      end

      default: state_d = tlpt_pkg::S_IDLE;
    endcase

    if (done && out_free) state_d = tlpt_pkg::S_IDLE;

    res.pages_in_use = res_clear ? 5'd0 : 5'(count_q);
    res.memory_bytes = tlpt_pkg::mem_bytes(res_clear ? '0 : count_q, bits_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= tlpt_pkg::S_IDLE;
      bits_q      <= tlpt_pkg::BitsReset;
      count_q     <= '0;
      cursor_q    <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      cursor_q <= cursor_d;
      if (cfg_we_i) begin
        // New width empties the table
        bits_q  <= tlpt_pkg::clamp_bits(cfg_wdata_i);
        count_q <= '0;
      end else begin
        count_q <= count_d;
      end
      if (done && out_free) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      act_q   <= in_data_i.action;
      dec_q   <= in_dec;
      frame_q <= tlpt_pkg::FrameW'(in_data_i.frame_number);
    end
    page_q <= page_d;
    if (done && out_free) out_q <= res;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
